### rtl/sparse_set_dirty_tracker_assert.svh
// Assertion macros used by the checker file of the sparse set dirty tracker.
`ifndef SPARSE_SET_DIRTY_TRACKER_ASSERT_SVH
`define SPARSE_SET_DIRTY_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSDT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SSDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/ssdt_pkg.sv
// Shared constants, opcodes, micro-operation codes and interface types of the tracker.
package ssdt_pkg;

   localparam int MAX_ENTITIES = 1024;
   localparam int ENT_W        = 10;
   localparam int CNT_W        = $clog2(MAX_ENTITIES + 1);
   localparam int OP_W         = 4;
   localparam int ST_W         = 2;
   localparam int TOMB_W       = 2;
   localparam int UOP_W        = 5;

   localparam logic [OP_W-1:0] OP_ADD       = 4'd0;
   localparam logic [OP_W-1:0] OP_REMOVE    = 4'd1;
   localparam logic [OP_W-1:0] OP_DESTROY   = 4'd2;
   localparam logic [OP_W-1:0] OP_CLR_DIRTY = 4'd3;
   localparam logic [OP_W-1:0] OP_MARK      = 4'd4;
   localparam logic [OP_W-1:0] OP_QUERY     = 4'd5;
   localparam logic [OP_W-1:0] OP_SWAP      = 4'd6;
   localparam logic [OP_W-1:0] OP_CLR_ALL   = 4'd7;
   localparam logic [OP_W-1:0] OP_READ_SLOT = 4'd8;

   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

   localparam logic [TOMB_W-1:0] TOMB_NONE    = 2'd0;
   localparam logic [TOMB_W-1:0] TOMB_REMOVED = 2'd1;
   localparam logic [TOMB_W-1:0] TOMB_DESTROY = 2'd3;

   localparam logic [UOP_W-1:0] U_NOP     = 5'd0;
   localparam logic [UOP_W-1:0] U_CLR     = 5'd1;
   localparam logic [UOP_W-1:0] U_LATCH   = 5'd2;
   localparam logic [UOP_W-1:0] U_RD1     = 5'd3;
   localparam logic [UOP_W-1:0] U_RD2     = 5'd4;
   localparam logic [UOP_W-1:0] U_CHK     = 5'd5;
   localparam logic [UOP_W-1:0] U_TOUCH   = 5'd6;
   localparam logic [UOP_W-1:0] U_UNTOUCH = 5'd7;
   localparam logic [UOP_W-1:0] U_SETST   = 5'd8;
   localparam logic [UOP_W-1:0] U_APPEND  = 5'd9;
   localparam logic [UOP_W-1:0] U_TDROP0  = 5'd10;
   localparam logic [UOP_W-1:0] U_TRD     = 5'd11;
   localparam logic [UOP_W-1:0] U_TCMP    = 5'd12;
   localparam logic [UOP_W-1:0] U_TEND    = 5'd13;
   localparam logic [UOP_W-1:0] U_RMRD    = 5'd14;
   localparam logic [UOP_W-1:0] U_RMW1    = 5'd15;
   localparam logic [UOP_W-1:0] U_RMW2    = 5'd16;
   localparam logic [UOP_W-1:0] U_SWRA    = 5'd17;
   localparam logic [UOP_W-1:0] U_SWRB    = 5'd18;
   localparam logic [UOP_W-1:0] U_SWW1    = 5'd19;
   localparam logic [UOP_W-1:0] U_SWW2    = 5'd20;
   localparam logic [UOP_W-1:0] U_CA0     = 5'd21;
   localparam logic [UOP_W-1:0] U_CA      = 5'd22;
   localparam logic [UOP_W-1:0] U_RSRD    = 5'd23;
   localparam logic [UOP_W-1:0] U_RSCAP   = 5'd24;
   localparam logic [UOP_W-1:0] U_OUT     = 5'd25;

   typedef struct packed {
      logic [UOP_W-1:0] uop;
      logic [ST_W-1:0]  stat;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            pres;
      logic            tomb_nz;
      logic            full;
      logic            a_eq_b;
      logic            a_oor;
      logic            b_oor;
      logic            walk_done;
      logic            sweep_last;
      logic            out_busy;
   } flags_type;

endpackage

### rtl/ssdt_ctrl.sv
// Sequencer that steps each transaction through its memory micro-operations.
module ssdt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ssdt_pkg::flags_type flags,
   output ssdt_pkg::cmd_type  cmd
);

   localparam logic [4:0] S_CLR     = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_RD1     = 5'd2;
   localparam logic [4:0] S_RD2     = 5'd3;
   localparam logic [4:0] S_CHK     = 5'd4;
   localparam logic [4:0] S_DISP    = 5'd5;
   localparam logic [4:0] S_TOUCH   = 5'd6;
   localparam logic [4:0] S_UNTOUCH = 5'd7;
   localparam logic [4:0] S_SETST   = 5'd8;
   localparam logic [4:0] S_APP     = 5'd9;
   localparam logic [4:0] S_TD0     = 5'd10;
   localparam logic [4:0] S_TRD     = 5'd11;
   localparam logic [4:0] S_TCMP    = 5'd12;
   localparam logic [4:0] S_RMRD    = 5'd13;
   localparam logic [4:0] S_RMW1    = 5'd14;
   localparam logic [4:0] S_RMW2    = 5'd15;
   localparam logic [4:0] S_SWRA    = 5'd16;
   localparam logic [4:0] S_SWRB    = 5'd17;
   localparam logic [4:0] S_SWW1    = 5'd18;
   localparam logic [4:0] S_SWW2    = 5'd19;
   localparam logic [4:0] S_CA0     = 5'd20;
   localparam logic [4:0] S_CA      = 5'd21;
   localparam logic [4:0] S_RSRD    = 5'd22;
   localparam logic [4:0] S_RSCAP   = 5'd23;
   localparam logic [4:0] S_FRD1    = 5'd24;
   localparam logic [4:0] S_FRD2    = 5'd25;
   localparam logic [4:0] S_FCHK    = 5'd26;
   localparam logic [4:0] S_OUT     = 5'd27;

   logic [4:0]                state_ff, state_in;
   logic [ssdt_pkg::ST_W-1:0] st_ff, st_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd.uop  = ssdt_pkg::U_NOP;
      cmd.stat = st_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.uop = ssdt_pkg::U_CLR;
            if (flags.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.uop = ssdt_pkg::U_LATCH;
            if (req_valid) state_in = S_RD1;
         end
         S_RD1: begin
            cmd.uop  = ssdt_pkg::U_RD1;
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.uop  = ssdt_pkg::U_RD2;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.uop  = ssdt_pkg::U_CHK;
            state_in = S_DISP;
         end
         S_DISP: begin
            state_in = S_FRD1;
            unique case (flags.op)
               ssdt_pkg::OP_ADD: begin
                  if (flags.pres) begin
                     state_in = S_TOUCH;
                  end else if (flags.full) begin
                     st_in    = ssdt_pkg::ST_FULL;
                     state_in = S_SETST;
                  end else if (flags.tomb_nz) begin
                     state_in = S_TD0;
                  end else begin
                     state_in = S_APP;
                  end
               end
               ssdt_pkg::OP_REMOVE, ssdt_pkg::OP_DESTROY: begin
                  if (flags.pres) begin
                     state_in = S_RMRD;
                  end else begin
                     st_in    = ssdt_pkg::ST_ABSENT;
                     state_in = S_SETST;
                  end
               end
               ssdt_pkg::OP_CLR_DIRTY: begin
                  if (flags.pres) begin
                     state_in = S_UNTOUCH;
                  end else if (flags.tomb_nz) begin
                     state_in = S_TD0;
                  end else begin
                     st_in    = ssdt_pkg::ST_ABSENT;
                     state_in = S_SETST;
                  end
               end
               ssdt_pkg::OP_MARK: begin
                  if (flags.pres) begin
                     state_in = S_TOUCH;
                  end else begin
                     st_in    = ssdt_pkg::ST_ABSENT;
                     state_in = S_SETST;
                  end
               end
               ssdt_pkg::OP_QUERY: begin
                  if (!flags.pres) begin
                     st_in    = ssdt_pkg::ST_ABSENT;
                     state_in = S_SETST;
                  end
               end
               ssdt_pkg::OP_SWAP: begin
                  if (flags.a_eq_b) begin
                     state_in = S_FRD1;
                  end else if (flags.a_oor || flags.b_oor) begin
                     st_in    = ssdt_pkg::ST_RANGE;
                     state_in = S_SETST;
                  end else begin
                     state_in = S_SWRA;
                  end
               end
               ssdt_pkg::OP_CLR_ALL: state_in = S_CA0;
               ssdt_pkg::OP_READ_SLOT: begin
                  if (flags.a_oor) begin
                     st_in    = ssdt_pkg::ST_RANGE;
                     state_in = S_SETST;
                  end else begin
                     state_in = S_RSRD;
                  end
               end
               default: state_in = S_FRD1;
            endcase
         end
         S_TOUCH: begin
            cmd.uop  = ssdt_pkg::U_TOUCH;
            state_in = S_FRD1;
         end
         S_UNTOUCH: begin
            cmd.uop  = ssdt_pkg::U_UNTOUCH;
            state_in = S_FRD1;
         end
         S_SETST: begin
            cmd.uop  = ssdt_pkg::U_SETST;
            state_in = S_FRD1;
         end
         S_APP: begin
            cmd.uop  = ssdt_pkg::U_APPEND;
            state_in = S_FRD1;
         end
         S_TD0: begin
            cmd.uop  = ssdt_pkg::U_TDROP0;
            state_in = S_TRD;
         end
         S_TRD: begin
            if (flags.walk_done) begin
               cmd.uop  = ssdt_pkg::U_TEND;
               state_in = (flags.op == ssdt_pkg::OP_ADD) ? S_APP : S_FRD1;
            end else begin
               cmd.uop  = ssdt_pkg::U_TRD;
               state_in = S_TCMP;
            end
         end
         S_TCMP: begin
            cmd.uop  = ssdt_pkg::U_TCMP;
            state_in = S_TRD;
         end
         S_RMRD: begin
            cmd.uop  = ssdt_pkg::U_RMRD;
            state_in = S_RMW1;
         end
         S_RMW1: begin
            cmd.uop  = ssdt_pkg::U_RMW1;
            state_in = S_RMW2;
         end
         S_RMW2: begin
            cmd.uop  = ssdt_pkg::U_RMW2;
            state_in = S_FRD1;
         end
         S_SWRA: begin
            cmd.uop  = ssdt_pkg::U_SWRA;
            state_in = S_SWRB;
         end
         S_SWRB: begin
            cmd.uop  = ssdt_pkg::U_SWRB;
            state_in = S_SWW1;
         end
         S_SWW1: begin
            cmd.uop  = ssdt_pkg::U_SWW1;
            state_in = S_SWW2;
         end
         S_SWW2: begin
            cmd.uop  = ssdt_pkg::U_SWW2;
            state_in = S_FRD1;
         end
         S_CA0: begin
            cmd.uop  = ssdt_pkg::U_CA0;
            state_in = S_CA;
         end
         S_CA: begin
            cmd.uop = ssdt_pkg::U_CA;
            if (flags.sweep_last) state_in = S_FRD1;
         end
         S_RSRD: begin
            cmd.uop  = ssdt_pkg::U_RSRD;
            state_in = S_RSCAP;
         end
         S_RSCAP: begin
            cmd.uop  = ssdt_pkg::U_RSCAP;
            state_in = S_FRD1;
         end
         S_FRD1: begin
            cmd.uop  = ssdt_pkg::U_RD1;
            state_in = S_FRD2;
         end
         S_FRD2: begin
            cmd.uop  = ssdt_pkg::U_RD2;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            cmd.uop  = ssdt_pkg::U_CHK;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!flags.out_busy) begin
               cmd.uop  = ssdt_pkg::U_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         st_ff    <= ssdt_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

endmodule

### rtl/ssdt_dpath.sv
// Datapath holding the sparse map, dense list, tombstone memories, counters and result register.
module ssdt_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  ssdt_pkg::cmd_type           cmd,
   output ssdt_pkg::flags_type         flags,
   input  logic [ssdt_pkg::OP_W-1:0]   req_opcode,
   input  logic [ssdt_pkg::ENT_W-1:0]  req_entity_index,
   input  logic [ssdt_pkg::ENT_W-1:0]  req_slot_a,
   input  logic [ssdt_pkg::ENT_W-1:0]  req_slot_b,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ssdt_pkg::ST_W-1:0]   rsp_status,
   output logic                        rsp_present,
   output logic [ssdt_pkg::ENT_W-1:0]  rsp_dense_slot,
   output logic                        rsp_dirty_flag,
   output logic [ssdt_pkg::TOMB_W-1:0] rsp_tomb_flags,
   output logic [ssdt_pkg::ENT_W-1:0]  rsp_slot_entity,
   output logic [ssdt_pkg::CNT_W-1:0]  rsp_live_total,
   output logic [ssdt_pkg::CNT_W-1:0]  rsp_tomb_total,
   output logic                        rsp_any_dirty
);

   localparam int EW = ssdt_pkg::ENT_W;
   localparam int CW = ssdt_pkg::CNT_W;
   localparam int TW = ssdt_pkg::TOMB_W;
   localparam logic [CW-1:0] NONE = CW'(ssdt_pkg::MAX_ENTITIES);
   localparam logic [CW-1:0] LAST_IDX = CW'(ssdt_pkg::MAX_ENTITIES - 1);

   logic [CW-1:0] soe_mem  [ssdt_pkg::MAX_ENTITIES];
   logic [EW-1:0] eos_mem  [ssdt_pkg::MAX_ENTITIES];
   logic          sd_mem   [ssdt_pkg::MAX_ENTITIES];
   logic [TW-1:0] tomb_mem [ssdt_pkg::MAX_ENTITIES];
   logic [EW-1:0] tl_mem   [ssdt_pkg::MAX_ENTITIES];

   logic          soe_we, eos_we, sd_we, tomb_we, tl_we;
   logic [EW-1:0] soe_wa, soe_ra, eos_wa, eos_ra, sd_wa, sd_ra;
   logic [EW-1:0] tomb_wa, tomb_ra, tl_wa, tl_ra;
   logic [CW-1:0] soe_wd;
   logic [EW-1:0] eos_wd, tl_wd;
   logic          sd_wd;
   logic [TW-1:0] tomb_wd;

   logic [CW-1:0] soe_rd_ff;
   logic [EW-1:0] eos_rd_ff, tl_rd_ff;
   logic          sd_rd_ff;
   logic [TW-1:0] tomb_rd_ff;

   logic [ssdt_pkg::OP_W-1:0] op_ff, op_in;
   logic [EW-1:0] e_ff, e_in, a_ff, a_in, b_ff, b_in;
   logic [CW-1:0] s_ff, s_in;
   logic [TW-1:0] tomb_ff, tomb_in;
   logic          pres_ff, pres_in, dirty_ff, dirty_in;
   logic [ssdt_pkg::ST_W-1:0] status_ff, status_in;
   logic [EW-1:0] slot_ent_ff, slot_ent_in, ea_ff, ea_in;
   logic          da_ff, da_in, found_ff, found_in;
   logic [CW-1:0] idx_ff, idx_in, live_ff, live_in, dcnt_ff, dcnt_in, tcnt_ff, tcnt_in;
   logic [CW-1:0] last, idx_prev;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ssdt_pkg::ST_W-1:0]   rsp_status_ff;
   logic                        rsp_present_ff, rsp_dirty_ff, rsp_any_ff;
   logic [EW-1:0]               rsp_dslot_ff, rsp_slot_ent_ff;
   logic [TW-1:0]               rsp_tomb_ff;
   logic [CW-1:0]               rsp_live_ff, rsp_tomb_tot_ff;

   assign last     = live_ff - 1'b1;
   assign idx_prev = idx_ff - 1'b1;

   assign flags.op         = op_ff;
   assign flags.pres       = pres_ff;
   assign flags.tomb_nz    = (tomb_ff != ssdt_pkg::TOMB_NONE);
   assign flags.full       = (live_ff == NONE);
   assign flags.a_eq_b     = (a_ff == b_ff);
   assign flags.a_oor      = ({1'b0, a_ff} >= live_ff);
   assign flags.b_oor      = ({1'b0, b_ff} >= live_ff);
   assign flags.walk_done  = (idx_ff >= tcnt_ff);
   assign flags.sweep_last = (idx_ff == LAST_IDX);
   assign flags.out_busy   = rsp_valid_ff && rsp_stall;

   always_comb begin
      soe_we = 1'b0;  soe_wa = e_ff;  soe_wd = NONE;  soe_ra = e_ff;
      eos_we = 1'b0;  eos_wa = a_ff;  eos_wd = e_ff;  eos_ra = a_ff;
      sd_we  = 1'b0;  sd_wa  = a_ff;  sd_wd  = 1'b0;  sd_ra  = a_ff;
      tomb_we = 1'b0; tomb_wa = e_ff; tomb_wd = ssdt_pkg::TOMB_NONE; tomb_ra = e_ff;
      tl_we  = 1'b0;  tl_wa  = tcnt_ff[EW-1:0]; tl_wd = e_ff; tl_ra = idx_ff[EW-1:0];
      op_in = op_ff; e_in = e_ff; a_in = a_ff; b_in = b_ff;
      s_in = s_ff; tomb_in = tomb_ff; pres_in = pres_ff; dirty_in = dirty_ff;
      status_in = status_ff; slot_ent_in = slot_ent_ff; ea_in = ea_ff; da_in = da_ff;
      found_in = found_ff; idx_in = idx_ff; live_in = live_ff;
      dcnt_in = dcnt_ff; tcnt_in = tcnt_ff;
      unique case (cmd.uop)
         ssdt_pkg::U_CLR: begin
            soe_we  = 1'b1; soe_wa = idx_ff[EW-1:0]; soe_wd = NONE;
            tomb_we = 1'b1; tomb_wa = idx_ff[EW-1:0];
            idx_in  = idx_ff + 1'b1;
         end
         ssdt_pkg::U_LATCH: begin
            op_in = req_opcode; e_in = req_entity_index;
            a_in = req_slot_a; b_in = req_slot_b;
            status_in = ssdt_pkg::ST_OK; slot_ent_in = '0;
         end
         ssdt_pkg::U_RD1: begin
            soe_ra = e_ff; tomb_ra = e_ff;
         end
         ssdt_pkg::U_RD2: begin
            s_in = soe_rd_ff; tomb_in = tomb_rd_ff;
            eos_ra = soe_rd_ff[EW-1:0]; sd_ra = soe_rd_ff[EW-1:0];
         end
         ssdt_pkg::U_CHK: begin
            pres_in  = (s_ff < live_ff) && (eos_rd_ff == e_ff);
            dirty_in = sd_rd_ff;
         end
         ssdt_pkg::U_TOUCH: begin
            sd_we = 1'b1; sd_wa = s_ff[EW-1:0]; sd_wd = 1'b1;
            if (!dirty_ff) dcnt_in = dcnt_ff + 1'b1;
         end
         ssdt_pkg::U_UNTOUCH: begin
            sd_we = 1'b1; sd_wa = s_ff[EW-1:0]; sd_wd = 1'b0;
            if (dirty_ff && dcnt_ff != '0) dcnt_in = dcnt_ff - 1'b1;
         end
         ssdt_pkg::U_SETST: status_in = cmd.stat;
         ssdt_pkg::U_APPEND: begin
            eos_we = 1'b1; eos_wa = live_ff[EW-1:0]; eos_wd = e_ff;
            sd_we  = 1'b1; sd_wa  = live_ff[EW-1:0]; sd_wd  = 1'b1;
            soe_we = 1'b1; soe_wa = e_ff; soe_wd = live_ff;
            dcnt_in = dcnt_ff + 1'b1;
            live_in = live_ff + 1'b1;
         end
         ssdt_pkg::U_TDROP0: begin
            tomb_we = 1'b1; tomb_wa = e_ff; tomb_wd = ssdt_pkg::TOMB_NONE;
            idx_in = '0; found_in = 1'b0;
         end
         ssdt_pkg::U_TRD: tl_ra = idx_ff[EW-1:0];
         ssdt_pkg::U_TCMP: begin
            idx_in = idx_ff + 1'b1;
            if (!found_ff) begin
               if (tl_rd_ff == e_ff) found_in = 1'b1;
            end else begin
               tl_we = 1'b1; tl_wa = idx_prev[EW-1:0]; tl_wd = tl_rd_ff;
            end
         end
         ssdt_pkg::U_TEND: if (found_ff) tcnt_in = tcnt_ff - 1'b1;
         ssdt_pkg::U_RMRD: begin
            eos_ra = last[EW-1:0]; sd_ra = last[EW-1:0];
         end
         ssdt_pkg::U_RMW1: begin
            if (s_ff != last) begin
               eos_we = 1'b1; eos_wa = s_ff[EW-1:0]; eos_wd = eos_rd_ff;
               sd_we  = 1'b1; sd_wa  = s_ff[EW-1:0]; sd_wd  = sd_rd_ff;
               soe_we = 1'b1; soe_wa = eos_rd_ff; soe_wd = s_ff;
            end
            if (dirty_ff && dcnt_ff != '0) dcnt_in = dcnt_ff - 1'b1;
            tomb_we = 1'b1; tomb_wa = e_ff;
            tomb_wd = (op_ff == ssdt_pkg::OP_DESTROY) ? ssdt_pkg::TOMB_DESTROY
                                                      : ssdt_pkg::TOMB_REMOVED;
            if (tomb_ff == ssdt_pkg::TOMB_NONE && tcnt_ff < NONE) begin
               tl_we = 1'b1; tl_wa = tcnt_ff[EW-1:0]; tl_wd = e_ff;
               tcnt_in = tcnt_ff + 1'b1;
            end
         end
         ssdt_pkg::U_RMW2: begin
            soe_we = 1'b1; soe_wa = e_ff; soe_wd = NONE;
            sd_we  = 1'b1; sd_wa  = last[EW-1:0]; sd_wd = 1'b0;
            live_in = last;
         end
         ssdt_pkg::U_SWRA: begin
            eos_ra = a_ff; sd_ra = a_ff;
         end
         ssdt_pkg::U_SWRB: begin
            ea_in = eos_rd_ff; da_in = sd_rd_ff;
            eos_ra = b_ff; sd_ra = b_ff;
         end
         ssdt_pkg::U_SWW1: begin
            eos_we = 1'b1; eos_wa = a_ff; eos_wd = eos_rd_ff;
            sd_we  = 1'b1; sd_wa  = a_ff; sd_wd  = sd_rd_ff;
            soe_we = 1'b1; soe_wa = eos_rd_ff; soe_wd = {1'b0, a_ff};
         end
         ssdt_pkg::U_SWW2: begin
            eos_we = 1'b1; eos_wa = b_ff; eos_wd = ea_ff;
            sd_we  = 1'b1; sd_wa  = b_ff; sd_wd  = da_ff;
            soe_we = 1'b1; soe_wa = ea_ff; soe_wd = {1'b0, b_ff};
         end
         ssdt_pkg::U_CA0: begin
            idx_in = '0; dcnt_in = '0; tcnt_in = '0;
         end
         ssdt_pkg::U_CA: begin
            sd_we   = 1'b1; sd_wa   = idx_ff[EW-1:0]; sd_wd = 1'b0;
            tomb_we = 1'b1; tomb_wa = idx_ff[EW-1:0];
            idx_in  = idx_ff + 1'b1;
         end
         ssdt_pkg::U_RSRD: eos_ra = a_ff;
         ssdt_pkg::U_RSCAP: slot_ent_in = eos_rd_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (soe_we) soe_mem[soe_wa] <= soe_wd;
      soe_rd_ff <= soe_mem[soe_ra];
      if (eos_we) eos_mem[eos_wa] <= eos_wd;
      eos_rd_ff <= eos_mem[eos_ra];
      if (sd_we) sd_mem[sd_wa] <= sd_wd;
      sd_rd_ff <= sd_mem[sd_ra];
      if (tomb_we) tomb_mem[tomb_wa] <= tomb_wd;
      tomb_rd_ff <= tomb_mem[tomb_ra];
      if (tl_we) tl_mem[tl_wa] <= tl_wd;
      tl_rd_ff <= tl_mem[tl_ra];
   end

   assign rsp_valid_in = (cmd.uop == ssdt_pkg::U_OUT) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      op_ff <= op_in; e_ff <= e_in; a_ff <= a_in; b_ff <= b_in;
      s_ff <= s_in; tomb_ff <= tomb_in; pres_ff <= pres_in; dirty_ff <= dirty_in;
      status_ff <= status_in; slot_ent_ff <= slot_ent_in;
      ea_ff <= ea_in; da_ff <= da_in; found_ff <= found_in;
      if (cmd.uop == ssdt_pkg::U_OUT) begin
         rsp_status_ff   <= status_ff;
         rsp_present_ff  <= pres_ff;
         rsp_dslot_ff    <= pres_ff ? s_ff[EW-1:0] : '0;
         rsp_dirty_ff    <= pres_ff ? dirty_ff : (tomb_ff != ssdt_pkg::TOMB_NONE);
         rsp_tomb_ff     <= tomb_ff;
         rsp_slot_ent_ff <= slot_ent_ff;
         rsp_live_ff     <= live_ff;
         rsp_tomb_tot_ff <= tcnt_ff;
         rsp_any_ff      <= (dcnt_ff != '0) || (tcnt_ff != '0);
      end
      if (reset) begin
         idx_ff       <= '0;
         live_ff      <= '0;
         dcnt_ff      <= '0;
         tcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         live_ff      <= live_in;
         dcnt_ff      <= dcnt_in;
         tcnt_ff      <= tcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_present     = rsp_present_ff;
   assign rsp_dense_slot  = rsp_dslot_ff;
   assign rsp_dirty_flag  = rsp_dirty_ff;
   assign rsp_tomb_flags  = rsp_tomb_ff;
   assign rsp_slot_entity = rsp_slot_ent_ff;
   assign rsp_live_total  = rsp_live_ff;
   assign rsp_tomb_total  = rsp_tomb_tot_ff;
   assign rsp_any_dirty   = rsp_any_ff;

endmodule

### rtl/sparse_set_dirty_tracker.sv
// Top level of the sparse set dirty tracker: sequencer plus datapath.
// The request channel (req_*) carries one operation per transaction: opcode,
// entity index and two dense slots. The response channel (rsp_*) returns one
// transaction per request with status, presence, slot, dirty and tombstone
// flags, the slot entity for a slot read, and the live and tombstone totals.
// Requests are taken one at a time; req_stall stays high while one is in work.
// When an operation's response is registered and rsp_valid rises, the
// sequencer is back in idle and can accept the next request.
// The path is a lookup of the sparse map and then the dense list and dirty
// bits, the operation's own memory steps and a second lookup that reports the
// entity's state after the operation, on memories with one read and one write
// port each. Dropping a tombstone walks the tombstone list entry by entry,
// shifting the later entries down. Clear all dirty sweeps every entry.
// After reset a clearing pass over every entry initializes the sparse map and
// tombstone flags; req_stall is high until it ends.
// A finished response sits in an output register; a new request is accepted
// and processed while it waits. If rsp_stall holds the response, the next one
// waits in the sequencer until the register is free.
module sparse_set_dirty_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ssdt_pkg::OP_W-1:0]   req_opcode,
   input  logic [ssdt_pkg::ENT_W-1:0]  req_entity_index,
   input  logic [ssdt_pkg::ENT_W-1:0]  req_slot_a,
   input  logic [ssdt_pkg::ENT_W-1:0]  req_slot_b,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ssdt_pkg::ST_W-1:0]   rsp_status,
   output logic                        rsp_present,
   output logic [ssdt_pkg::ENT_W-1:0]  rsp_dense_slot,
   output logic                        rsp_dirty_flag,
   output logic [ssdt_pkg::TOMB_W-1:0] rsp_tomb_flags,
   output logic [ssdt_pkg::ENT_W-1:0]  rsp_slot_entity,
   output logic [ssdt_pkg::CNT_W-1:0]  rsp_live_total,
   output logic [ssdt_pkg::CNT_W-1:0]  rsp_tomb_total,
   output logic                        rsp_any_dirty
);

   ssdt_pkg::cmd_type   cmd;
   ssdt_pkg::flags_type flags;

   ssdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   ssdt_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .flags            (flags),
      .req_opcode       (req_opcode),
      .req_entity_index (req_entity_index),
      .req_slot_a       (req_slot_a),
      .req_slot_b       (req_slot_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_present      (rsp_present),
      .rsp_dense_slot   (rsp_dense_slot),
      .rsp_dirty_flag   (rsp_dirty_flag),
      .rsp_tomb_flags   (rsp_tomb_flags),
      .rsp_slot_entity  (rsp_slot_entity),
      .rsp_live_total   (rsp_live_total),
      .rsp_tomb_total   (rsp_tomb_total),
      .rsp_any_dirty    (rsp_any_dirty)
   );

endmodule

### rtl/ssdt_checker.sv
// Port-level checker for the sparse set dirty tracker and its bind statement.
`include "sparse_set_dirty_tracker_assert.svh"

module ssdt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_present,
   input logic [ssdt_pkg::ENT_W-1:0]  rsp_dense_slot,
   input logic                        rsp_dirty_flag,
   input logic [ssdt_pkg::TOMB_W-1:0] rsp_tomb_flags,
   input logic [ssdt_pkg::CNT_W-1:0]  rsp_live_total
);

   `SSDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SSDT_ASSERT_IMPL(a_slot_zero, clock, reset, rsp_valid && !rsp_present, rsp_dense_slot == '0)
   `SSDT_ASSERT_IMPL(a_absent_dirty, clock, reset, rsp_valid && !rsp_present, rsp_dirty_flag == (rsp_tomb_flags != '0))
   `SSDT_ASSERT_IMPL(a_present_no_tomb, clock, reset, rsp_valid && rsp_present, rsp_tomb_flags == '0)
   `SSDT_ASSERT_IMPL(a_slot_live, clock, reset, rsp_valid && rsp_present, {1'b0, rsp_dense_slot} < rsp_live_total)

endmodule

bind sparse_set_dirty_tracker ssdt_checker u_ssdt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_present    (rsp_present),
   .rsp_dense_slot (rsp_dense_slot),
   .rsp_dirty_flag (rsp_dirty_flag),
   .rsp_tomb_flags (rsp_tomb_flags),
   .rsp_live_total (rsp_live_total)
);

### tb/sparse_set_dirty_tracker_tb.sv
// Self-checking testbench of the sparse set dirty tracker with a table model and idle mixes.
`timescale 1ns / 100ps

module sparse_set_dirty_tracker_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int EW = ssdt_pkg::ENT_W;
   localparam int CW = ssdt_pkg::CNT_W;
   localparam int OW = ssdt_pkg::OP_W;
   localparam logic [ssdt_pkg::OP_W-1:0] OP_UNUSED_LO = 4'd9;
   localparam logic [ssdt_pkg::OP_W-1:0] OP_UNUSED_HI = 4'd15;

   typedef struct {
      logic [ssdt_pkg::ST_W-1:0]   status;
      logic                        present;
      logic [ssdt_pkg::ENT_W-1:0]  dense_slot;
      logic                        dirty_flag;
      logic [ssdt_pkg::TOMB_W-1:0] tomb_flags;
      logic [ssdt_pkg::ENT_W-1:0]  slot_entity;
      logic [ssdt_pkg::CNT_W-1:0]  live_total;
      logic [ssdt_pkg::CNT_W-1:0]  tomb_total;
      logic                        any_dirty;
   } table_rsp_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [ssdt_pkg::OP_W-1:0] req_opcode;
   logic [ssdt_pkg::ENT_W-1:0] req_entity_index;
   logic [ssdt_pkg::ENT_W-1:0] req_slot_a;
   logic [ssdt_pkg::ENT_W-1:0] req_slot_b;
   logic rsp_valid;
   logic rsp_stall;
   logic [ssdt_pkg::ST_W-1:0] rsp_status;
   logic rsp_present;
   logic [ssdt_pkg::ENT_W-1:0] rsp_dense_slot;
   logic rsp_dirty_flag;
   logic [ssdt_pkg::TOMB_W-1:0] rsp_tomb_flags;
   logic [ssdt_pkg::ENT_W-1:0] rsp_slot_entity;
   logic [ssdt_pkg::CNT_W-1:0] rsp_live_total;
   logic [ssdt_pkg::CNT_W-1:0] rsp_tomb_total;
   logic rsp_any_dirty;

   int slot_of [ssdt_pkg::MAX_ENTITIES];
   int ent_of [ssdt_pkg::MAX_ENTITIES];
   bit slot_dirty [ssdt_pkg::MAX_ENTITIES];
   logic [ssdt_pkg::TOMB_W-1:0] ent_tomb [ssdt_pkg::MAX_ENTITIES];
   int tomb_order [ssdt_pkg::MAX_ENTITIES];
   int live_cnt;
   int dirty_cnt;
   int tomb_cnt;

   table_rsp_type pending_rsp [$];
   int send_idle_pct;
   int recv_idle_pct;
   int hold_len;
   int error_count;
   int ops_sent;
   int rsp_checked;
   int peak_live;
   int idle_cycles;

   sparse_set_dirty_tracker u_top (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic bit is_member(int e);
      return slot_of[e] < live_cnt && ent_of[slot_of[e]] == e;
   endfunction

   function automatic void set_dirty(int s);
      if (!slot_dirty[s]) begin
         slot_dirty[s] = 1'b1;
         dirty_cnt++;
      end
   endfunction

   function automatic void unset_dirty(int s);
      if (slot_dirty[s]) begin
         slot_dirty[s] = 1'b0;
         if (dirty_cnt > 0) dirty_cnt--;
      end
   endfunction

   function automatic void drop_tomb(int e);
      int i;
      if (ent_tomb[e] == ssdt_pkg::TOMB_NONE) return;
      ent_tomb[e] = ssdt_pkg::TOMB_NONE;
      for (i = 0; i < tomb_cnt; i++) begin
         if (tomb_order[i] == e) begin
            for (; i + 1 < tomb_cnt; i++) tomb_order[i] = tomb_order[i + 1];
            tomb_cnt--;
            return;
         end
      end
   endfunction

   function automatic table_rsp_type apply_table_op(logic [ssdt_pkg::OP_W-1:0] op, int e,
                                                    int a, int b);
      table_rsp_type r;
      bit pres;
      int s;
      int last;
      int moved;
      int ea;
      int eb;
      bit t;
      r.status = ssdt_pkg::ST_OK;
      r.slot_entity = '0;
      pres = is_member(e);
      case (op)
         ssdt_pkg::OP_ADD: begin
            if (pres) begin
               set_dirty(slot_of[e]);
            end else if (live_cnt >= ssdt_pkg::MAX_ENTITIES) begin
               r.status = ssdt_pkg::ST_FULL;
            end else begin
               drop_tomb(e);
               ent_of[live_cnt] = e;
               slot_dirty[live_cnt] = 1'b1;
               dirty_cnt++;
               slot_of[e] = live_cnt;
               live_cnt++;
            end
         end
         ssdt_pkg::OP_REMOVE, ssdt_pkg::OP_DESTROY: begin
            if (!pres) begin
               r.status = ssdt_pkg::ST_ABSENT;
            end else begin
               s = slot_of[e];
               last = live_cnt - 1;
               unset_dirty(s);
               if (s != last) begin
                  moved = ent_of[last];
                  ent_of[s] = moved;
                  slot_dirty[s] = slot_dirty[last];
                  slot_of[moved] = s;
               end
               slot_of[e] = ssdt_pkg::MAX_ENTITIES;
               slot_dirty[last] = 1'b0;
               live_cnt--;
               if (ent_tomb[e] == ssdt_pkg::TOMB_NONE && tomb_cnt < ssdt_pkg::MAX_ENTITIES) begin
                  tomb_order[tomb_cnt] = e;
                  tomb_cnt++;
               end
               ent_tomb[e] = (op == ssdt_pkg::OP_DESTROY) ? ssdt_pkg::TOMB_DESTROY
                                                          : ssdt_pkg::TOMB_REMOVED;
            end
         end
         ssdt_pkg::OP_CLR_DIRTY: begin
            if (pres) unset_dirty(slot_of[e]);
            else if (ent_tomb[e] != ssdt_pkg::TOMB_NONE) drop_tomb(e);
            else r.status = ssdt_pkg::ST_ABSENT;
         end
         ssdt_pkg::OP_MARK: begin
            if (pres) set_dirty(slot_of[e]);
            else r.status = ssdt_pkg::ST_ABSENT;
         end
         ssdt_pkg::OP_QUERY: begin
            if (!pres) r.status = ssdt_pkg::ST_ABSENT;
         end
         ssdt_pkg::OP_SWAP: begin
            if (a != b) begin
               if (a >= live_cnt || b >= live_cnt) begin
                  r.status = ssdt_pkg::ST_RANGE;
               end else begin
                  ea = ent_of[a];
                  eb = ent_of[b];
                  ent_of[a] = eb;
                  ent_of[b] = ea;
                  slot_of[ea] = b;
                  slot_of[eb] = a;
                  t = slot_dirty[a];
                  slot_dirty[a] = slot_dirty[b];
                  slot_dirty[b] = t;
               end
            end
         end
         ssdt_pkg::OP_CLR_ALL: begin
            for (int i = 0; i < ssdt_pkg::MAX_ENTITIES; i++) begin
               slot_dirty[i] = 1'b0;
               ent_tomb[i] = ssdt_pkg::TOMB_NONE;
            end
            dirty_cnt = 0;
            tomb_cnt = 0;
         end
         ssdt_pkg::OP_READ_SLOT: begin
            if (a < live_cnt) r.slot_entity = EW'(ent_of[a]);
            else r.status = ssdt_pkg::ST_RANGE;
         end
         default: ;
      endcase
      pres = is_member(e);
      r.present = pres;
      r.dense_slot = EW'(pres ? slot_of[e] : 0);
      r.tomb_flags = ent_tomb[e];
      r.dirty_flag = pres ? slot_dirty[slot_of[e]] : (ent_tomb[e] != ssdt_pkg::TOMB_NONE);
      r.live_total = CW'(live_cnt);
      r.tomb_total = CW'(tomb_cnt);
      r.any_dirty = (dirty_cnt != 0 || tomb_cnt != 0);
      if (live_cnt > peak_live) peak_live = live_cnt;
      return r;
   endfunction

   task automatic send_op(logic [ssdt_pkg::OP_W-1:0] op, int e, int a, int b);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entity_index <= EW'(e);
      req_slot_a <= EW'(a);
      req_slot_b <= EW'(b);
      do @(posedge clock); while (req_stall);
      pending_rsp.insert(pending_rsp.size(), apply_table_op(op, e, a, b));
      ops_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      table_rsp_type x;
      if (rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("response transaction with none outstanding");
            error_count++;
         end else begin
            x = pending_rsp.pop_front();
            rsp_checked++;
            check_field("status", x.status, rsp_status);
            check_field("present", x.present, rsp_present);
            check_field("dense_slot", x.dense_slot, rsp_dense_slot);
            check_field("dirty_flag", x.dirty_flag, rsp_dirty_flag);
            check_field("tomb_flags", x.tomb_flags, rsp_tomb_flags);
            check_field("slot_entity", x.slot_entity, rsp_slot_entity);
            check_field("live_total", x.live_total, rsp_live_total);
            check_field("tomb_total", x.tomb_total, rsp_tomb_total);
            check_field("any_dirty", x.any_dirty, rsp_any_dirty);
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_len > 0) begin
         rsp_stall <= 1'b1;
         hold_len = hold_len - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d cycles without a transaction.", idle_cycles);
         $display("sparse_set_dirty_tracker verification failed");
         $finish;
      end
   end

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(ssdt_pkg::OP_ADD, 0, 0, 0);
      send_op(ssdt_pkg::OP_ADD, 1023, 1023, 1023);
      send_op(ssdt_pkg::OP_ADD, 5, 0, 0);
      send_op(ssdt_pkg::OP_ADD, 5, 0, 0);
      send_op(ssdt_pkg::OP_QUERY, 5, 0, 0);
      send_op(ssdt_pkg::OP_MARK, 1023, 0, 0);
      send_op(ssdt_pkg::OP_CLR_DIRTY, 5, 0, 0);
      send_op(ssdt_pkg::OP_READ_SLOT, 0, 0, 0);
      send_op(ssdt_pkg::OP_READ_SLOT, 0, 1023, 0);
      send_op(ssdt_pkg::OP_SWAP, 5, 0, 2);
      send_op(ssdt_pkg::OP_SWAP, 5, 3, 3);
      send_op(ssdt_pkg::OP_SWAP, 5, 1023, 1023);
      send_op(ssdt_pkg::OP_SWAP, 5, 0, 900);
      send_op(ssdt_pkg::OP_REMOVE, 0, 0, 0);
      send_op(ssdt_pkg::OP_DESTROY, 1023, 0, 0);
      send_op(ssdt_pkg::OP_QUERY, 1023, 0, 0);
      send_op(ssdt_pkg::OP_CLR_DIRTY, 1023, 0, 0);
      send_op(ssdt_pkg::OP_CLR_DIRTY, 1023, 0, 0);
      send_op(ssdt_pkg::OP_REMOVE, 777, 0, 0);
      send_op(ssdt_pkg::OP_DESTROY, 777, 0, 0);
      send_op(ssdt_pkg::OP_MARK, 777, 0, 0);
      send_op(ssdt_pkg::OP_CLR_ALL, 5, 0, 0);
      send_op(ssdt_pkg::OP_ADD, 0, 0, 0);
      send_op(OP_UNUSED_LO, 0, 0, 0);
      send_op(OP_UNUSED_HI, 1023, 1023, 1023);
   endtask

   task automatic test_random(int count);
      int pick;
      int e;
      int a;
      int b;
      logic [ssdt_pkg::OP_W-1:0] op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 30) op = ssdt_pkg::OP_ADD;
         else if (pick < 42) op = ssdt_pkg::OP_REMOVE;
         else if (pick < 50) op = ssdt_pkg::OP_DESTROY;
         else if (pick < 60) op = ssdt_pkg::OP_CLR_DIRTY;
         else if (pick < 68) op = ssdt_pkg::OP_MARK;
         else if (pick < 77) op = ssdt_pkg::OP_QUERY;
         else if (pick < 87) op = ssdt_pkg::OP_SWAP;
         else if (pick < 89) op = ssdt_pkg::OP_CLR_ALL;
         else if (pick < 97) op = ssdt_pkg::OP_READ_SLOT;
         else op = OW'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
         e = ($urandom_range(99) < 80) ? $urandom_range(47) : $urandom_range(1023);
         a = ($urandom_range(99) < 75) ? $urandom_range(live_cnt) : $urandom_range(1023);
         b = ($urandom_range(99) < 75) ? $urandom_range(live_cnt) : $urandom_range(1023);
         send_op(op, e, a, b);
      end
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_len = 400;
      for (int n = 0; n < 8; n++) send_op(ssdt_pkg::OP_ADD, $urandom_range(47), 0, 0);
   endtask

   initial begin
      for (int i = 0; i < ssdt_pkg::MAX_ENTITIES; i++) begin
         slot_of[i] = ssdt_pkg::MAX_ENTITIES;
         ent_of[i] = 0;
         slot_dirty[i] = 1'b0;
         ent_tomb[i] = ssdt_pkg::TOMB_NONE;
         tomb_order[i] = 0;
      end
      live_cnt = 0;
      dirty_cnt = 0;
      tomb_cnt = 0;
      error_count = 0;
      ops_sent = 0;
      rsp_checked = 0;
      peak_live = 0;
      idle_cycles = 0;
      hold_len = 0;
      send_idle_pct = 8;
      recv_idle_pct = 86;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= ssdt_pkg::OP_QUERY;
      req_entity_index <= '0;
      req_slot_a <= '0;
      req_slot_b <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(220);
      send_idle_pct = 86;
      recv_idle_pct = 8;
      test_random(220);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(220);
      test_backpressure();

      wait_drained();
      repeat (40) @(posedge clock);
      $display("Sent %0d operations across three idle mixes and a long response hold;",
               ops_sent);
      $display("%0d responses checked, peak live count %0d.", rsp_checked, peak_live);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("sparse_set_dirty_tracker verification clean");
      end else begin
         $display("sparse_set_dirty_tracker verification failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/ssdt_pkg.sv
rtl/ssdt_ctrl.sv
rtl/ssdt_dpath.sv
rtl/sparse_set_dirty_tracker.sv
rtl/ssdt_checker.sv
tb/sparse_set_dirty_tracker_tb.sv
